/* hdl/hrhp_pkg.sv */
package hrhp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd1;
    localparam logic [2:0] KIND_VALUE  = 3'd2;
    localparam logic [2:0] KIND_HEADER = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // Parser phases
    localparam logic [2:0] PH_SEEK_SPACE = 3'd0;
    localparam logic [2:0] PH_STATUS     = 3'd1;
    localparam logic [2:0] PH_SEEK_LF    = 3'd2;
    localparam logic [2:0] PH_NAME       = 3'd3;
    localparam logic [2:0] PH_SKIP       = 3'd4;
    localparam logic [2:0] PH_VALUE      = 3'd5;
    localparam logic [2:0] PH_DONE       = 3'd6;

    // Characters of interest
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [7:0] MAX_HEADERS_RESET = 8'd16;

    typedef logic [2:0] kind_t;

endpackage

/* hdl/http_response_header_parser.sv */
// An accepted byte sits in the input register; its result is loaded into the
// result register. Throughput: one byte per cycle while results are taken;
// the slave side stalls only when both registers are full and the result waits.
// Reset (rst_n low, asynchronous): pipeline emptied, parser back to seeking the
// first space, status and header count cleared, max_headers set to 16.
module http_response_header_parser
    import hrhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: max_headers
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // Input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] start_req
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] data_byte, [39:8] status_code,
                                        // [47:40] header_total
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // finished
);

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    // Result register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [31:0] out_status_reg;
    logic [7:0]  out_total_reg;
    logic        out_fin_reg;

    // Parser state
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] status_acc_reg, status_acc_next;
    logic [7:0]  header_count_reg, header_count_next;
    logic [1:0]  skip_left_reg, skip_left_next;
    logic [7:0]  max_headers_reg;

    // Result of the byte in the input register
    logic        res_valid;
    kind_t       res_kind;
    logic [7:0]  res_byte;
    logic [31:0] res_status;
    logic        res_fin;

    logic        out_free;
    logic        proc;

    logic [2:0]  ph;
    logic [31:0] acc;
    logic [7:0]  cnt;
    logic [1:0]  skp;
    logic [7:0]  cnt_inc;
    logic [31:0] acc_step;
    logic [1:0]  skp_dec;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    // Decode one byte against the current parser state
    always_comb
    begin
        // A start flag restarts the parser before the byte is handled
        ph  = in_start_reg ? PH_SEEK_SPACE : phase_reg;
        acc = in_start_reg ? 32'd0 : status_acc_reg;
        cnt = in_start_reg ? 8'd0 : header_count_reg;
        skp = in_start_reg ? 2'd0 : skip_left_reg;

        cnt_inc  = cnt + 8'd1;
        acc_step = {acc[28:0], 3'b000} + {acc[30:0], 1'b0}
                   + {24'd0, in_byte_reg} - {24'd0, CHAR_ZERO};
        skp_dec  = (skp != 2'd0) ? skp - 2'd1 : skp;

        phase_next        = ph;
        status_acc_next   = acc;
        header_count_next = cnt;
        skip_left_next    = skp;

        res_valid  = 1'b0;
        res_kind   = KIND_END;
        res_byte   = 8'd0;
        res_status = 32'd0;
        res_fin    = 1'b0;

        case (ph)
            PH_SEEK_SPACE:
            begin
                if (in_byte_reg == CHAR_NUL)
                begin
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res_fin    = 1'b1;
                end
                else if (in_byte_reg == CHAR_SPACE)
                begin
                    status_acc_next = 32'd0;
                    phase_next      = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (in_byte_reg == CHAR_SPACE)
                begin
                    phase_next = PH_SEEK_LF;
                    res_valid  = 1'b1;
                    res_kind   = KIND_STATUS;
                    res_status = acc;
                end
                else
                begin
                    status_acc_next = acc_step;
                end
            end
            PH_SEEK_LF:
            begin
                if (in_byte_reg == CHAR_NUL)
                begin
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res_fin    = 1'b1;
                end
                else if (in_byte_reg == CHAR_LF)
                begin
                    phase_next = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (in_byte_reg inside {CHAR_CR, CHAR_LF, CHAR_NUL})
                begin
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res_fin    = 1'b1;
                end
                else if (in_byte_reg == CHAR_COLON)
                begin
                    skip_left_next = 2'd1;
                    phase_next     = PH_SKIP;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_NAME;
                    res_byte  = in_byte_reg;
                end
            end
            PH_SKIP:
            begin
                if (in_byte_reg == CHAR_NUL)
                begin
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res_fin    = 1'b1;
                end
                else
                begin
                    skip_left_next = skp_dec;
                    if (skp_dec == 2'd0)
                    begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                if (in_byte_reg inside {CHAR_LF, CHAR_NUL})
                begin
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res_fin    = 1'b1;
                end
                else if (in_byte_reg == CHAR_CR)
                begin
                    // Count the header and end once the limit is reached
                    header_count_next = cnt_inc;
                    res_valid         = 1'b1;
                    res_kind          = KIND_HEADER;
                    if (cnt_inc >= max_headers_reg)
                    begin
                        phase_next = PH_DONE;
                        res_fin    = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SEEK_LF;
                    end
                end
                else
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_VALUE;
                    res_byte  = in_byte_reg;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_headers_reg <= MAX_HEADERS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_headers_reg <= cfg_data;
        end
    end

    // Capture an input transaction, drop it once processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // Advance the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SEEK_SPACE;
            status_acc_reg   <= 32'd0;
            header_count_reg <= 8'd0;
            skip_left_reg    <= 2'd0;
        end
        else if (proc)
        begin
            phase_reg        <= phase_next;
            status_acc_reg   <= status_acc_next;
            header_count_reg <= header_count_next;
            skip_left_reg    <= skip_left_next;
        end
    end

    // Load the result register or empty it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_kind_reg   <= res_kind;
            out_byte_reg   <= res_byte;
            out_status_reg <= res_status;
            out_total_reg  <= header_count_next;
            out_fin_reg    <= res_fin;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_total_reg, out_status_reg, out_byte_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_fin_reg;

`ifndef NO_ASSERTIONS
    // A finishing result leaves the parser in the done phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && res_valid && res_fin) |=> (phase_reg == PH_DONE))
        else $error("finishing result did not end the parse");

    // Only a header or end result may finish the parse
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser == KIND_END || m_axis_tuser == KIND_HEADER))
        else $error("finished set on a wrong kind");

    // Data byte is carried only by name and value results
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_NAME && m_axis_tuser != KIND_VALUE)
            |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("data byte set on a non-byte result");

    // A held result stays put until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("result register changed while stalled");
`endif

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrhp_pkg::*;

    localparam int RESULT_LATENCY = 2;
    localparam int RANDOM_ITEMS   = 300;
    localparam int LONG_HOLD      = 300;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [31:0] status_code;
        logic [7:0]  header_total;
        logic        finished;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;   // [0] start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [7:0] data_byte, [39:8] status_code,
                                        // [47:40] header_total
    logic [2:0]  m_axis_tuser;          // [2:0] kind
    logic        m_axis_tlast;

    // Parser state as the bytes are accepted
    logic [2:0]  pr_phase = PH_SEEK_SPACE;
    logic [31:0] pr_status = 32'd0;
    logic [7:0]  pr_headers = 8'd0;
    logic [1:0]  pr_skip = 2'd0;
    logic [7:0]  pr_max_headers = MAX_HEADERS_RESET;

    parse_result_t pending_results[$];
    logic [7:0]    response_q[$];

    int  mismatch_count = 0;
    int  live_items = 0;
    int  cycle_count = 0;
    bit  idle_en = 1'b1;
    bit  sink_hold_req = 1'b0;

    http_response_header_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long
    function automatic int idle_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic parse_result_t make_result(kind_t k, logic [7:0] d,
                                                  logic [31:0] s, logic fin);
        parse_result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.status_code  = s;
        r.header_total = pr_headers;
        r.finished     = fin;
        return r;
    endfunction

    // Advance the parser by one byte and queue the result it produces
    function automatic void predict_parse(logic [7:0] b, logic restart);
        if (restart)
        begin
            pr_phase   = PH_SEEK_SPACE;
            pr_status  = 32'd0;
            pr_headers = 8'd0;
            pr_skip    = 2'd0;
        end
        case (pr_phase)
            PH_SEEK_SPACE:
            begin
                if (b == CHAR_NUL)
                begin
                    pr_phase = PH_DONE;
                    pending_results.push_back(make_result(KIND_END, 8'd0, 32'd0, 1'b1));
                end
                else if (b == CHAR_SPACE)
                begin
                    pr_status = 32'd0;
                    pr_phase  = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (b == CHAR_SPACE)
                begin
                    pr_phase = PH_SEEK_LF;
                    pending_results.push_back(make_result(KIND_STATUS, 8'd0, pr_status, 1'b0));
                end
                else
                    pr_status = pr_status * 32'd10 + ({24'd0, b} - {24'd0, CHAR_ZERO});
            end
            PH_SEEK_LF:
            begin
                if (b == CHAR_NUL)
                begin
                    pr_phase = PH_DONE;
                    pending_results.push_back(make_result(KIND_END, 8'd0, 32'd0, 1'b1));
                end
                else if (b == CHAR_LF)
                    pr_phase = PH_NAME;
            end
            PH_NAME:
            begin
                if (b == CHAR_CR || b == CHAR_LF || b == CHAR_NUL)
                begin
                    pr_phase = PH_DONE;
                    pending_results.push_back(make_result(KIND_END, 8'd0, 32'd0, 1'b1));
                end
                else if (b == CHAR_COLON)
                begin
                    pr_skip  = 2'd1;
                    pr_phase = PH_SKIP;
                end
                else
                    pending_results.push_back(make_result(KIND_NAME, b, 32'd0, 1'b0));
            end
            PH_SKIP:
            begin
                if (b == CHAR_NUL)
                begin
                    pr_phase = PH_DONE;
                    pending_results.push_back(make_result(KIND_END, 8'd0, 32'd0, 1'b1));
                end
                else
                begin
                    if (pr_skip > 2'd0)
                        pr_skip = pr_skip - 2'd1;
                    if (pr_skip == 2'd0)
                        pr_phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (b == CHAR_LF || b == CHAR_NUL)
                begin
                    pr_phase = PH_DONE;
                    pending_results.push_back(make_result(KIND_END, 8'd0, 32'd0, 1'b1));
                end
                else if (b == CHAR_CR)
                begin
                    pr_headers = pr_headers + 8'd1;
                    if (pr_headers >= pr_max_headers)
                    begin
                        pr_phase = PH_DONE;
                        pending_results.push_back(
                            make_result(KIND_HEADER, 8'd0, 32'd0, 1'b1));
                    end
                    else
                    begin
                        pr_phase = PH_SEEK_LF;
                        pending_results.push_back(
                            make_result(KIND_HEADER, 8'd0, 32'd0, 1'b0));
                    end
                end
                else
                    pending_results.push_back(make_result(KIND_VALUE, b, 32'd0, 1'b0));
            end
            default:
                pr_phase = PH_DONE;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    // Compare one result transaction with the oldest expectation
    function automatic void check_result();
        parse_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            $error("kind mismatch: expected none, actual %0h", m_axis_tuser);
            return;
        end
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
        check_field("status_code", want.status_code, m_axis_tdata[39:8]);
        check_field("header_total", 32'(want.header_total), 32'(m_axis_tdata[47:40]));
        check_field("finished", 32'(want.finished), 32'(m_axis_tlast));
    endfunction

    // Result side: check each transaction, then pick the next tready
    initial
    begin : result_sink
        int stall_left;
        int gap;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_result();
            if (sink_hold_req)
            begin
                stall_left    = LONG_HOLD;
                sink_hold_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                gap = idle_gap();
                if (gap > 0)
                    stall_left = gap - 1;
                m_axis_tready <= (gap == 0);
            end
        end
    end

    // Offer one byte and hold it until the parser takes it
    task automatic send_byte(input logic [7:0] b, input logic restart);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_axis_tready);
        live_items++;
        predict_parse(b, restart);
    endtask

    task automatic send_text(input string s, input bit restart_first);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], restart_first && i == 0);
    endtask

    task automatic send_response();
        foreach (response_q[i])
            send_byte(response_q[i], i == 0);
    endtask

    // Stop offering and wait for every expected result
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_max_headers(input logic [7:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pr_max_headers = value;
    endtask

    // Text byte: never NUL, CR or LF, optionally never a colon or a space
    function automatic logic [7:0] pick_byte(bit no_colon, bit no_space);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CHAR_LF || b == CHAR_CR || (no_colon && b == CHAR_COLON) ||
               (no_space && b == CHAR_SPACE));
        return b;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            response_q.push_back(s[i]);
    endfunction

    // Status line followed by n minimal headers
    function automatic void build_header_run(int n);
        response_q.delete();
        push_text("HTTP/1.1 200 OK\r\n");
        repeat (n)
        begin
            response_q.push_back(pick_byte(1'b1, 1'b0));
            push_text(": \r\n");
        end
        push_text("\r\n");
    endfunction

    // Well-formed response with random content, optionally with one byte broken
    function automatic void build_response(int n_hdr, bit mangle);
        int         n;
        int         pos;
        logic [7:0] b;
        response_q.delete();
        n = $urandom_range(1, 8);
        repeat (n) response_q.push_back(pick_byte(1'b1, 1'b1));
        response_q.push_back(CHAR_SPACE);
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 85)
                b = CHAR_ZERO + 8'($urandom_range(0, 9));
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHAR_SPACE);
            end
            response_q.push_back(b);
        end
        response_q.push_back(CHAR_SPACE);
        n = $urandom_range(0, 6);
        repeat (n) response_q.push_back(pick_byte(1'b0, 1'b0));
        push_text("\r\n");
        repeat (n_hdr)
        begin
            n = $urandom_range(1, 6);
            repeat (n) response_q.push_back(pick_byte(1'b1, 1'b0));
            response_q.push_back(CHAR_COLON);
            response_q.push_back(($urandom_range(0, 3) == 0) ? pick_byte(1'b0, 1'b0)
                                                             : CHAR_SPACE);
            n = $urandom_range(0, 8);
            repeat (n) response_q.push_back(pick_byte(1'b0, 1'b0));
            push_text("\r\n");
        end
        push_text("\r\n");
        if (mangle)
        begin
            pos = $urandom_range(0, response_q.size() - 1);
            case ($urandom_range(0, 3))
                0:       response_q[pos] = CHAR_NUL;
                1:       response_q[pos] = CHAR_LF;
                2:       response_q[pos] = CHAR_CR;
                default: response_q[pos] = 8'($urandom_range(0, 255));
            endcase
        end
        // trailing bytes after the parse has ended
        if ($urandom_range(0, 9) < 3)
        begin
            n = $urandom_range(1, 4);
            repeat (n) response_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 9) == 0);
    endtask

    // Header limit at its reset value of 16
    task automatic test_default_limit();
        build_header_run(17);
        send_response();
        wait_results_drained();
    endtask

    task automatic test_directed_cases();
        // all-ones value byte; the empty line ends the parse
        send_text(" 42 \nN: ", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_text("\r\n\r", 1'b0);
        // NUL while seeking the first space
        send_byte(CHAR_NUL, 1'b1);
        // NUL kept in the status, status wraps, LF in a name
        send_text(" 9", 1'b1);
        send_byte(CHAR_NUL, 1'b0);
        send_text("9999999999 \nab\n", 1'b0);
        // NUL while seeking a line feed
        send_text(" 1 x", 1'b1);
        send_byte(CHAR_NUL, 1'b0);
        // NUL in the byte skipped after the colon
        send_text(" 1 \nk:", 1'b1);
        send_byte(CHAR_NUL, 1'b0);
        // colon as the skipped byte, then NUL in the value
        send_text(" 1 \nk::v", 1'b1);
        send_byte(CHAR_NUL, 1'b0);
        // LF in a value; the bytes after it are dropped
        send_text(" 1 \nk: v\nzz", 1'b1);
        // restart in the middle of a value, then NUL in a name
        send_text(" 1 \nk: v", 1'b1);
        send_text(" 7 \n", 1'b1);
        send_byte(CHAR_NUL, 1'b0);
        wait_results_drained();
    endtask

    // Header limit at small values
    task automatic test_header_limit();
        write_max_headers(8'd1);
        build_header_run(3);
        send_response();
        write_max_headers(8'd2);
        build_header_run(3);
        send_response();
        wait_results_drained();
    endtask

    // Hold the result side off while bytes keep coming
    task automatic test_backpressure();
        idle_en       = 1'b0;
        sink_hold_req = 1'b1;
        write_max_headers(8'd16);
        build_response(12, 1'b0);
        send_response();
        wait_results_drained();
        idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        int         stop_at;
        int         target;
        int         round;
        int         sel;
        logic [7:0] setting;
        stop_at = live_items + RANDOM_ITEMS;
        round   = 0;
        while (live_items < stop_at)
        begin
            case (round)
                0:       setting = 8'd1;
                1:       setting = 8'd255;
                2:       setting = 8'd2;
                default: setting = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(1, 24))
                                                               : 8'($urandom_range(1, 255));
            endcase
            write_max_headers(setting);
            idle_en = ($urandom_range(0, 3) != 0);
            target  = live_items + 120;
            while (live_items < target)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    build_response($urandom_range(0, 20), 1'b0);
                else if (sel < 85)
                    build_response($urandom_range(0, 6), 1'b1);
                if (sel < 85)
                    send_response();
                else
                    send_noise();
            end
            round++;
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_limit();
        test_directed_cases();
        test_header_limit();
        test_backpressure();
        test_random_traffic();
        wait_results_drained();
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
